// ===== rtl/core/fqs_pkg.sv =====
package fqs_pkg;

   localparam int VALUE_W = 32;
   localparam int OCC_W   = 9;
   localparam int TOTAL_W = 40;

   // front/rear report for an empty queue
   localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_COUNT   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEQUEUE,
      ST_SCAN,
      ST_LOOKUP,
      ST_FETCH,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/fqs_ring_mem.sv =====
module fqs_ring_mem import fqs_pkg::*; #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_a_addr,
   input  logic [ADDR_W-1:0]  rd_b_addr,
   output logic [VALUE_W-1:0] rd_a_data,
   output logic [VALUE_W-1:0] rd_b_data
);

   logic [VALUE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// ===== rtl/core/fqs_mean_divider.sv =====
module fqs_mean_divider import fqs_pkg::*; #(
   parameter int SUM_W = 41,
   parameter int CNT_W = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SUM_W-1:0]   dividend,
   input  logic        [CNT_W-1:0]   divisor,
   output logic                      done,
   output logic signed [VALUE_W-1:0] quotient
);

   localparam int STEP_W = $clog2(VALUE_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [VALUE_W-1:0] work_ff;
   logic [CNT_W-1:0]  div_ff;
   logic              neg_ff;

   logic [SUM_W-1:0]  mag;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   // |mean| < 2^32, so the bits above the low word are already below the divisor
   assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
   assign trial = {rem_ff, work_ff[VALUE_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= CNT_W'(mag >> VALUE_W);
         work_ff <= mag[VALUE_W-1:0];
         div_ff  <= divisor;
         neg_ff  <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         work_ff <= {work_ff[VALUE_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? VALUE_W'(-work_ff) : work_ff;

endmodule

// ===== rtl/core/fifo_queue_with_statistics.sv =====
// FIFO queue of signed 32-bit words with running statistics.
// Request channel (req_valid/req_ready): req_action picks enqueue, dequeue,
// clear or count-matches; req_value is the word to store or to look for.
// Response channel (rsp_valid/rsp_ready): one response word per request with
// status, removed word, front/rear words (-1 when empty), occupancy, the
// exact running total and its mean truncated toward zero.
// One request is in flight at a time. After acceptance a dequeue first
// takes the head word, a count scans the queue (one store read per entry),
// then front and rear are read back and, most of the work, the 32-step
// mean divider runs, one quotient bit a cycle; when the queue ends up
// empty the divider is skipped. A new request is taken only once the
// previous response has been registered.
// Entries live in a ring store with two registered read ports; the sequencer
// orders writes ahead of the reads that need them.
// Reset (synchronous) empties the queue: pointers, count and total go to
// zero, no store clearing pass is needed; req_ready is low during reset.
// A stalled response sits in the output register; a new request is taken
// meanwhile and its result waits in the sequencer until the register frees.
module fifo_queue_with_statistics import fqs_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic        [1:0]         req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic        [1:0]         rsp_status,
   output logic signed [VALUE_W-1:0] rsp_removed_value,
   output logic signed [VALUE_W-1:0] rsp_front_value,
   output logic signed [VALUE_W-1:0] rsp_rear_value,
   output logic        [OCC_W-1:0]   rsp_occupancy,
   output logic signed [TOTAL_W-1:0] rsp_total,
   output logic signed [VALUE_W-1:0] rsp_average,
   output logic        [OCC_W-1:0]   rsp_match_count
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = 33 + $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
      return (a == LAST_ADDR) ? '0 : a + 1'b1;
   endfunction

   // sequencer and queue state
   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       head_ff, head_in;
   logic [ADDR_W-1:0]       tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   // per-request working registers
   action_type              action_ff, action_in;
   logic [VALUE_W-1:0]      value_ff, value_in;
   status_type              status_ff, status_in;
   logic [VALUE_W-1:0]      removed_ff, removed_in;
   logic [CNT_W-1:0]        match_ff, match_in;
   logic [ADDR_W-1:0]       scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]        scan_left_ff, scan_left_in;
   logic                    pend_ff, pend_in;
   logic [VALUE_W-1:0]      front_ff, front_in;
   logic [VALUE_W-1:0]      rear_ff, rear_in;
   logic                    empty_ff, empty_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]      rsp_removed_ff, rsp_removed_in;
   logic [VALUE_W-1:0]      rsp_front_ff, rsp_front_in;
   logic [VALUE_W-1:0]      rsp_rear_ff, rsp_rear_in;
   logic [OCC_W-1:0]        rsp_occ_ff, rsp_occ_in;
   logic [TOTAL_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [VALUE_W-1:0]      rsp_avg_ff, rsp_avg_in;
   logic [OCC_W-1:0]        rsp_match_ff, rsp_match_in;

   // store ports
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [VALUE_W-1:0]      wr_data;
   logic [ADDR_W-1:0]       rd_a_addr;
   logic [ADDR_W-1:0]       rd_b_addr;
   logic [VALUE_W-1:0]      rd_a_data;
   logic [VALUE_W-1:0]      rd_b_data;
   logic [ADDR_W-1:0]       rear_addr;

   logic                    div_start;
   logic                    div_done;
   logic signed [VALUE_W-1:0] div_quotient;

   assign rear_addr = (tail_ff == '0) ? LAST_ADDR : tail_ff - 1'b1;

   fqs_ring_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   fqs_mean_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_mean (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      action_in      = action_ff;
      value_in       = value_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      match_in       = match_ff;
      scan_ptr_in    = scan_ptr_ff;
      scan_left_in   = scan_left_ff;
      pend_in        = 1'b0;
      front_in       = front_ff;
      rear_in        = rear_ff;
      empty_in       = empty_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_front_in   = rsp_front_ff;
      rsp_rear_in    = rsp_rear_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_avg_in     = rsp_avg_ff;
      rsp_match_in   = rsp_match_ff;
      wr_en          = 1'b0;
      wr_addr        = tail_ff;
      wr_data        = req_value;
      rd_a_addr      = head_ff;
      rd_b_addr      = rear_addr;
      div_start      = 1'b0;
      req_ready      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && req_ready) begin
               action_in  = action_type'(req_action);
               value_in   = req_value;
               status_in  = STAT_OK;
               removed_in = '0;
               match_in   = '0;
               state_in   = ST_LOOKUP;
               case (action_type'(req_action))
                  ACT_ENQUEUE: begin
                     if (count_ff == FULL_CNT) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = next_addr(tail_ff);
                        count_in = count_ff + 1'b1;
                        sum_in   = sum_ff + SUM_W'(req_value);
                     end
                  end
                  ACT_DEQUEUE: begin
                     // head word is read this cycle on port A
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_DEQUEUE;
                     end
                  end
                  ACT_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                     sum_in   = '0;
                  end
                  default: begin
                     scan_ptr_in  = head_ff;
                     scan_left_in = count_ff;
                     state_in     = ST_SCAN;
                  end
               endcase
            end
         end
         ST_DEQUEUE: begin
            removed_in = rd_a_data;
            head_in    = next_addr(head_ff);
            count_in   = count_ff - 1'b1;
            sum_in     = sum_ff - SUM_W'($signed(rd_a_data));
            state_in   = ST_LOOKUP;
         end
         ST_SCAN: begin
            // one read issued per cycle, its compare lands in the next cycle
            rd_a_addr = scan_ptr_ff;
            if (scan_left_ff != '0) begin
               scan_ptr_in  = next_addr(scan_ptr_ff);
               scan_left_in = scan_left_ff - 1'b1;
               pend_in      = 1'b1;
            end
            if (pend_ff && (rd_a_data == value_ff)) begin
               match_in = match_ff + 1'b1;
            end
            if ((scan_left_ff == '0) && !pend_ff) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // ports A/B default to head and rear of the updated queue
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            empty_in = (count_ff == '0);
            front_in = (count_ff == '0) ? EMPTY_VALUE : rd_a_data;
            rear_in  = (count_ff == '0) ? EMPTY_VALUE : rd_b_data;
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_removed_in = removed_ff;
               rsp_front_in   = front_ff;
               rsp_rear_in    = rear_ff;
               rsp_occ_in     = OCC_W'(count_ff);
               rsp_total_in   = TOTAL_W'(sum_ff);
               rsp_avg_in     = empty_ff ? '0 : div_quotient;
               rsp_match_in   = OCC_W'(match_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      match_ff       <= match_in;
      scan_ptr_ff    <= scan_ptr_in;
      scan_left_ff   <= scan_left_in;
      front_ff       <= front_in;
      rear_ff        <= rear_in;
      empty_ff       <= empty_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_front_ff   <= rsp_front_in;
      rsp_rear_ff    <= rsp_rear_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_avg_ff     <= rsp_avg_in;
      rsp_match_ff   <= rsp_match_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_front_value   = rsp_front_ff;
   assign rsp_rear_value    = rsp_rear_ff;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_total         = rsp_total_ff;
   assign rsp_average       = rsp_avg_ff;
   assign rsp_match_count   = rsp_match_ff;

   // occupancy bound
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("occupancy beyond depth");

   // an empty queue carries no total
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0))
      else $error("nonzero total on empty queue");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ACT_CLEAR))
      |=> ((count_ff == '0) && (head_ff == '0) && (tail_ff == '0)))
      else $error("clear left state behind");

   a_enqueue: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ACT_ENQUEUE) && (count_ff != FULL_CNT))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("enqueue did not grow the queue");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import fqs_pkg::*;

   localparam int DEPTH        = 256;
   localparam int RANDOM_WORDS = 1800;
   localparam int IDLE_PCT     = 20;
   // extreme signed 32-bit words
   localparam logic signed [VALUE_W-1:0] TOP_WORD    = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] BOTTOM_WORD = 32'sh8000_0000;

   // one response word, field by field
   typedef struct {
      status_type                 status;
      logic signed [VALUE_W-1:0]  removed;
      logic signed [VALUE_W-1:0]  front;
      logic signed [VALUE_W-1:0]  rear;
      logic        [OCC_W-1:0]    occupancy;
      logic signed [TOTAL_W-1:0]  total;
      logic signed [VALUE_W-1:0]  average;
      logic        [OCC_W-1:0]    match_count;
   } queue_report_type;

   // directed row: when typed is set, report is the literal answer,
   // otherwise the shadow queue supplies it
   typedef struct {
      action_type                 action;
      logic signed [VALUE_W-1:0]  value;
      bit                         typed;
      queue_report_type           report;
   } stim_row_type;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_kind_type;

   // report of an empty queue after a harmless request
   localparam queue_report_type EMPTY_OK =
      '{STAT_OK, 0, EMPTY_VALUE, EMPTY_VALUE, 0, 0, 0, 0};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic        [1:0]         req_action = ACT_ENQUEUE;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic        [1:0]         rsp_status;
   logic signed [VALUE_W-1:0] rsp_removed_value;
   logic signed [VALUE_W-1:0] rsp_front_value;
   logic signed [VALUE_W-1:0] rsp_rear_value;
   logic        [OCC_W-1:0]   rsp_occupancy;
   logic signed [TOTAL_W-1:0] rsp_total;
   logic signed [VALUE_W-1:0] rsp_average;
   logic        [OCC_W-1:0]   rsp_match_count;

   // shadow of the queue contents and its exact sum
   logic signed [VALUE_W-1:0] held_words[$];
   longint                    held_total = 0;
   // reports owed by the block, oldest first
   queue_report_type          awaited_reports[$];
   int                        mismatch_count = 0;
   // chance (percent) that either side idles in a cycle; zeroed for a stretch
   int                        idle_pct = IDLE_PCT;
   stim_row_type              directed_rows [25];

   fifo_queue_with_statistics #(.DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_rear_value    (rsp_rear_value),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_total         (rsp_total),
      .rsp_average       (rsp_average),
      .rsp_match_count   (rsp_match_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one request to the shadow queue and return the report it earns.
   function automatic queue_report_type step_queue(action_type act,
                                                   logic signed [VALUE_W-1:0] val);
      queue_report_type rep;
      int               hits;
      rep = EMPTY_OK;
      hits = 0;
      case (act)
         ACT_ENQUEUE: begin
            if (held_words.size() >= DEPTH) begin
               rep.status = STAT_FULL;
            end else begin
               held_words.push_back(val);
               held_total += val;
            end
         end
         ACT_DEQUEUE: begin
            if (held_words.size() == 0) begin
               rep.status = STAT_EMPTY;
            end else begin
               rep.removed = held_words.pop_front();
               held_total -= rep.removed;
            end
         end
         ACT_CLEAR: begin
            held_words.delete();
            held_total = 0;
         end
         default: begin
            foreach (held_words[i])
               if (held_words[i] == val) hits++;
         end
      endcase
      rep.match_count = OCC_W'(hits);
      rep.occupancy = OCC_W'(held_words.size());
      rep.total = TOTAL_W'(held_total);
      if (held_words.size() != 0) begin
         rep.front = held_words[0];
         rep.rear = held_words[$];
         // longint division truncates toward zero, as the mean must
         rep.average = VALUE_W'(held_total / longint'(held_words.size()));
      end
      return rep;
   endfunction

   // Random word: a small range for repeats, the extremes, or anything.
   function automatic logic signed [VALUE_W-1:0] pick_word();
      int kind;
      kind = $urandom_range(9);
      if (kind < 3) return $urandom_range(8) - 4;
      if (kind == 3) return $urandom_range(1) ? TOP_WORD : BOTTOM_WORD;
      return $urandom;
   endfunction

   // Hold one request word on the channel until taken, then log what it owes.
   task automatic send_word(action_type act, logic signed [VALUE_W-1:0] val,
                            bit typed, queue_report_type given);
      queue_report_type predicted;
      req_valid <= 1'b1;
      req_action <= act;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      predicted = step_queue(act, val);
      if (typed) awaited_reports.push_back(given);
      else awaited_reports.push_back(predicted);
      // optional gap; valid drops in this step only if no word follows at once
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic check_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Response side: check each taken word against the oldest owed report,
   // then pick the next cycle's ready at random.
   always @(posedge clock) begin : rsp_side
      queue_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t: response word with nothing owed, status %0d",
                     $time, rsp_status);
            mismatch_count++;
         end else begin
            want = awaited_reports.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("removed_value", want.removed, rsp_removed_value);
            check_field("front_value", want.front, rsp_front_value);
            check_field("rear_value", want.rear, rsp_rear_value);
            check_field("occupancy", want.occupancy, rsp_occupancy);
            check_field("total", want.total, rsp_total);
            check_field("average", want.average, rsp_average);
            check_field("match_count", want.match_count, rsp_match_count);
         end
      end
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   initial begin
      phase_kind_type            phase;
      int                        phase_left;
      int                        sent;
      int                        r;
      bit                        one_extreme;
      logic signed [VALUE_W-1:0] extreme_word;
      logic signed [VALUE_W-1:0] val;
      action_type                act;

      // Directed part: empty-queue errors, extremes of the word, negative
      // means truncated toward zero, ring reuse after a clear.
      directed_rows = '{
         '{ACT_DEQUEUE, 0, 1'b1, '{STAT_EMPTY, 0, EMPTY_VALUE, EMPTY_VALUE, 0, 0, 0, 0}},
         '{ACT_COUNT, 0, 1'b1, EMPTY_OK},
         '{ACT_CLEAR, 0, 1'b1, EMPTY_OK},
         '{ACT_ENQUEUE, TOP_WORD, 1'b1,
           '{STAT_OK, 0, TOP_WORD, TOP_WORD, 1, TOP_WORD, TOP_WORD, 0}},
         // max + min = -1, mean -1/2 truncates to 0
         '{ACT_ENQUEUE, BOTTOM_WORD, 1'b1,
           '{STAT_OK, 0, TOP_WORD, BOTTOM_WORD, 2, -1, 0, 0}},
         '{ACT_ENQUEUE, -1, 1'b1, '{STAT_OK, 0, TOP_WORD, -1, 3, -2, 0, 0}},
         '{ACT_COUNT, -1, 1'b0, EMPTY_OK},
         '{ACT_COUNT, BOTTOM_WORD, 1'b0, EMPTY_OK},
         '{ACT_COUNT, 5, 1'b0, EMPTY_OK},
         '{ACT_DEQUEUE, 0, 1'b0, EMPTY_OK},
         '{ACT_DEQUEUE, 0, 1'b0, EMPTY_OK},
         '{ACT_ENQUEUE, -7, 1'b0, EMPTY_OK},
         '{ACT_ENQUEUE, 2, 1'b0, EMPTY_OK},
         '{ACT_ENQUEUE, 0, 1'b0, EMPTY_OK},   // -6/4 -> -1
         '{ACT_COUNT, -7, 1'b0, EMPTY_OK},
         '{ACT_DEQUEUE, 0, 1'b0, EMPTY_OK},
         '{ACT_DEQUEUE, 0, 1'b0, EMPTY_OK},
         '{ACT_DEQUEUE, 0, 1'b0, EMPTY_OK},
         '{ACT_DEQUEUE, 0, 1'b0, EMPTY_OK},
         '{ACT_DEQUEUE, 0, 1'b1, '{STAT_EMPTY, 0, EMPTY_VALUE, EMPTY_VALUE, 0, 0, 0, 0}},
         '{ACT_ENQUEUE, 32'sh5555_5555, 1'b0, EMPTY_OK},
         '{ACT_ENQUEUE, 32'shAAAA_AAAA, 1'b0, EMPTY_OK},
         '{ACT_COUNT, 32'shAAAA_AAAA, 1'b0, EMPTY_OK},
         '{ACT_CLEAR, 0, 1'b1, EMPTY_OK},
         '{ACT_ENQUEUE, 1, 1'b1, '{STAT_OK, 0, 1, 1, 1, 1, 1, 0}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].action, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].report);

      // Random part in phases: fill phases run the queue into full (and the
      // ring pointers around), drain phases empty it, mixed ones wander.
      // Some fill phases start from a clear and use one extreme word only,
      // driving the total to its limits.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         phase = phase_kind_type'($urandom_range(2));
         phase_left = $urandom_range(400, 40);
         one_extreme = ($urandom_range(3) == 0);
         extreme_word = $urandom_range(1) ? TOP_WORD : BOTTOM_WORD;
         if (one_extreme && phase == PHASE_FILL) begin
            send_word(ACT_CLEAR, pick_word(), 1'b0, EMPTY_OK);
            sent++;
         end
         while (phase_left > 0 && sent < RANDOM_WORDS) begin
            // long stretch with both sides always ready
            idle_pct = (sent >= 700 && sent < 1000) ? 0 : IDLE_PCT;
            r = $urandom_range(99);
            case (phase)
               PHASE_FILL:
                  act = (r < 80) ? ACT_ENQUEUE : (r < 88) ? ACT_DEQUEUE : ACT_COUNT;
               PHASE_DRAIN:
                  act = (r < 15) ? ACT_ENQUEUE : (r < 88) ? ACT_DEQUEUE : ACT_COUNT;
               default:
                  act = (r < 45) ? ACT_ENQUEUE : (r < 85) ? ACT_DEQUEUE :
                        (r < 98) ? ACT_COUNT : ACT_CLEAR;
            endcase
            val = one_extreme ? extreme_word : pick_word();
            // on a non-empty queue, half the counts look for a word that is actually held
            if (act == ACT_COUNT && held_words.size() != 0 && $urandom_range(1))
               val = held_words[$urandom_range(held_words.size() - 1)];
            send_word(act, val, 1'b0, EMPTY_OK);
            sent++;
            phase_left--;
         end
      end
      req_valid <= 1'b0;

      while (awaited_reports.size() != 0) @(posedge clock);
      // catch any stray word after the last owed one
      repeat (60) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #40_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
